FILE: src/rdf_pkg.sv
// Package for the repeater duplicate filter: ring geometry, verdict codes,
// and the command/status structs between controller and datapath.
// No dependencies.
package rdf_pkg;

    localparam int RING_DEPTH = 50;
    localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int ID_W       = 32;
    localparam int NUM_W      = 32;
    localparam int PAIR_W     = ID_W + NUM_W;
    localparam int VERDICT_W  = 2;
    localparam int SLOT_W     = 8;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_FORWARD   = 2'd0,
        VERDICT_INVALID   = 2'd1,
        VERDICT_OWN       = 2'd2,
        VERDICT_DUPLICATE = 2'd3
    } verdict_t;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture the input transfer, restart the scan
        logic rd_en;    // read the ring slot at the scan index, advance it
        logic publish;  // load the output register, update the ring on forward
    } rdf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic early_drop;  // invalid or own packet, no scan needed
        logic scan_last;   // scan index is at the last slot
        logic out_free;    // output register can take a result this cycle
    } rdf_stat_t;

endpackage

FILE: src/repeater_duplicate_filter.sv
// Top level of the repeater duplicate filter: joins controller and datapath.
// Depends on rdf_pkg, rdf_ctrl, rdf_dp (and rdf_ram through rdf_dp).
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+--------------------------------------------
//  input    | in_valid / in_ready    | packet_valid, sender_id, message_number
//  output   | out_valid / out_ready  | verdict, slot_written
//  config   | cfg_wr_en (no wait)    | cfg_wr_data (own node id)
//
// An invalid or own packet skips the ring scan and goes straight to the result;
// any other packet waits for the scan, which reads one ring slot per cycle
// through the single RAM read port.
// One packet is in flight at a time; the next input transfer is taken as soon
// as the result sits in the output register, even if it is still stalled.
// Reset clears the own id, the ring pointer and the per-slot valid bits, so the
// ring reads as all (0,0) pairs at once, with no clearing pass.
module repeater_duplicate_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [rdf_pkg::ID_W-1:0]      cfg_wr_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          packet_valid,
    input  logic [rdf_pkg::ID_W-1:0]      sender_id,
    input  logic [rdf_pkg::NUM_W-1:0]     message_number,
    // output channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rdf_pkg::VERDICT_W-1:0] verdict,
    output logic [rdf_pkg::SLOT_W-1:0]    slot_written
);

    import rdf_pkg::*;

    rdf_cmd_t  cmd;
    rdf_stat_t stat;

    // Sequence: capture, early check, scan the ring, drain, hand off
    rdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the packet, compare against each ring slot, update the ring on forward
    rdf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .packet_valid   (packet_valid),
        .sender_id      (sender_id),
        .message_number (message_number),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .verdict        (verdict),
        .slot_written   (slot_written),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

FILE: src/rdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdf_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 50,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/rdf_ctrl.sv
// Controller for the repeater duplicate filter: sequences capture, ring scan
// and result hand-off. Depends on rdf_pkg.
module rdf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rdf_pkg::rdf_stat_t stat,
    output rdf_pkg::rdf_cmd_t  cmd
);

    import rdf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = stat.early_drop ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/rdf_dp.sv
// Datapath for the repeater duplicate filter: own-id register, captured packet,
// ring memory with per-slot valid bits, scan compare and output register.
// Depends on rdf_pkg and rdf_ram.
module rdf_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [rdf_pkg::ID_W-1:0]     cfg_wr_data,
    input  logic                         packet_valid,
    input  logic [rdf_pkg::ID_W-1:0]     sender_id,
    input  logic [rdf_pkg::NUM_W-1:0]    message_number,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [rdf_pkg::VERDICT_W-1:0] verdict,
    output logic [rdf_pkg::SLOT_W-1:0]   slot_written,
    input  rdf_pkg::rdf_cmd_t            cmd,
    output rdf_pkg::rdf_stat_t           stat
);

    import rdf_pkg::*;

    logic [ID_W-1:0]       own_id_reg;
    logic                  pkt_vld_reg;
    logic [ID_W-1:0]       sender_reg;
    logic [NUM_W-1:0]      number_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      ptr_reg;
    logic [IDX_W-1:0]      ptr_next;
    logic [RING_DEPTH-1:0] entry_vld_reg;
    logic                  vld_rd_reg;
    logic                  cmp_en_reg;
    logic                  match_reg;
    logic                  out_valid_reg;
    verdict_t              verdict_reg;
    logic [SLOT_W-1:0]     slot_reg;

    logic [PAIR_W-1:0]     pair;
    logic [PAIR_W-1:0]     ram_rdata;
    logic                  hit;
    logic                  is_own;
    verdict_t              verdict_now;
    logic                  fwd;

    assign pair   = {sender_reg, number_reg};
    assign is_own = (sender_reg == own_id_reg);

    // A slot never written reads as the cleared pair (0,0)
    assign hit = vld_rd_reg ? (ram_rdata == pair) : (pair == '0);

    always_comb
    begin
        if (!pkt_vld_reg)
        begin
            verdict_now = VERDICT_INVALID;
        end
        else if (is_own)
        begin
            verdict_now = VERDICT_OWN;
        end
        else if (match_reg)
        begin
            verdict_now = VERDICT_DUPLICATE;
        end
        else
        begin
            verdict_now = VERDICT_FORWARD;
        end
    end

    assign fwd      = cmd.publish && (verdict_now == VERDICT_FORWARD);
    assign ptr_next = (ptr_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;

    rdf_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (fwd),
        .wr_addr (ptr_reg),
        .wr_data (pair),
        .rd_en   (cmd.rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg    <= '0;
            idx_reg       <= '0;
            ptr_reg       <= '0;
            entry_vld_reg <= '0;
            vld_rd_reg    <= 1'b0;
            cmp_en_reg    <= 1'b0;
            match_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                own_id_reg <= cfg_wr_data;
            end

            cmp_en_reg <= cmd.rd_en;
            if (cmd.load)
            begin
                idx_reg   <= '0;
                match_reg <= 1'b0;
            end
            else
            begin
                if (cmd.rd_en)
                begin
                    idx_reg    <= idx_reg + 1'b1;
                    vld_rd_reg <= entry_vld_reg[idx_reg];
                end
                if (cmp_en_reg && hit)
                begin
                    match_reg <= 1'b1;
                end
            end

            if (fwd)
            begin
                entry_vld_reg[ptr_reg] <= 1'b1;
                ptr_reg                <= ptr_next;
            end

            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pkt_vld_reg <= packet_valid;
            sender_reg  <= sender_id;
            number_reg  <= message_number;
        end
        if (cmd.publish)
        begin
            verdict_reg <= verdict_now;
            slot_reg    <= fwd ? SLOT_W'(ptr_reg) : '0;
        end
    end

    assign stat.early_drop = !pkt_vld_reg || is_own;
    assign stat.scan_last  = (idx_reg == IDX_W'(RING_DEPTH - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign verdict      = verdict_reg;
    assign slot_written = slot_reg;

endmodule

FILE: src/rdf_checker.sv
// Port-level checker for the repeater duplicate filter, bound to the top level.
// Depends on rdf_pkg and repeater_duplicate_filter.
module rdf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [rdf_pkg::VERDICT_W-1:0] verdict,
    input logic [rdf_pkg::SLOT_W-1:0]    slot_written
);

    import rdf_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(slot_written))
        else $error("stalled result changed or dropped");

    // One packet at a time: no transfer right after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a packet is in flight");

    // Dropped packets report slot zero
    a_drop_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (verdict != VERDICT_FORWARD) |-> slot_written == '0)
        else $error("dropped packet reports a ring slot");

    // Forwarded slot lies inside the ring
    a_fwd_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (verdict == VERDICT_FORWARD) |-> slot_written < SLOT_W'(RING_DEPTH))
        else $error("forward slot out of range");

endmodule

bind repeater_duplicate_filter rdf_checker u_rdf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .verdict      (verdict),
    .slot_written (slot_written)
);

FILE: tb/tb_top.sv
// Self-checking testbench for repeater_duplicate_filter: verdict and ring slot checks.
// It keeps its own model of the ring of recent pairs and the own node id.
// Depends on rdf_pkg and the repeater_duplicate_filter RTL.
`timescale 1ns / 100ps

module tb_top;
    import rdf_pkg::*;

    localparam int MAX_WAIT       = 18;
    localparam int WATCHDOG_LIMIT = 1000;          // cycles with no transfer at all
    localparam int TAIL_CYCLES    = RING_DEPTH + 10;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 100;

    typedef enum logic [1:0] {
        STIM_PACKET,
        STIM_CONFIG,
        STIM_DRAIN
    } stim_kind_t;

    typedef struct packed {
        stim_kind_t       kind;
        logic             pvalid;
        logic [ID_W-1:0]  sender;
        logic [NUM_W-1:0] number;
        logic [4:0]       gap;
        logic [ID_W-1:0]  own;
    } stim_entry_t;

    typedef struct packed {
        verdict_t          verdict;
        logic [SLOT_W-1:0] slot;
    } verdict_rec_t;

    typedef enum logic [1:0] {
        DRV_FETCH,
        DRV_GAP,
        DRV_HOLD,
        DRV_WAIT_IDLE
    } drv_state_t;

    // DUT inputs, all driven to known values from time zero
    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              cfg_wr_en      = 1'b0;
    logic [ID_W-1:0]   cfg_wr_data    = '0;
    logic              in_valid       = 1'b0;
    logic              in_ready;
    logic              packet_valid   = 1'b0;
    logic [ID_W-1:0]   sender_id      = '0;
    logic [NUM_W-1:0]  message_number = '0;
    logic              out_valid;
    logic              out_ready      = 1'b0;
    logic [VERDICT_W-1:0] verdict;
    logic [SLOT_W-1:0] slot_written;

    // Stimulus and expectations
    stim_entry_t       pending_stim[$];
    verdict_rec_t      verdict_q[$];
    logic [63:0]       recent_pairs[$];
    logic [ID_W-1:0]   sender_pool[8];

    // Filter model state
    logic [ID_W-1:0]   model_own_id;
    logic [ID_W-1:0]   hist_sender[RING_DEPTH];
    logic [NUM_W-1:0]  hist_number[RING_DEPTH];
    logic [7:0]        hist_ptr;

    // Handshake flags registered at the rising edge, read by the drivers
    logic              in_fire  = 1'b0;
    logic              out_fire = 1'b0;

    int                err_count   = 0;
    int                idle_cycles = 0;
    drv_state_t        drv_state   = DRV_FETCH;
    stim_entry_t       cur_stim;
    int unsigned       tx_gap      = 0;
    int unsigned       rx_wait     = 0;
    int unsigned       rx_calm     = 0;

    repeater_duplicate_filter DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .packet_valid   (packet_valid),
        .sender_id      (sender_id),
        .message_number (message_number),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .verdict        (verdict),
        .slot_written   (slot_written)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Work out the verdict for one packet and update the ring on forward.
    // Priority: invalid first, then own packet, then duplicate.
    function automatic verdict_rec_t judge_packet(input logic pv,
                                                  input logic [ID_W-1:0] snd,
                                                  input logic [NUM_W-1:0] num);
        verdict_rec_t rec;
        logic         hit;
        int unsigned  p;
        rec.verdict = VERDICT_FORWARD;
        rec.slot    = '0;
        hit         = 1'b0;
        if (!pv)
            rec.verdict = VERDICT_INVALID;
        else if (snd == model_own_id)
            rec.verdict = VERDICT_OWN;
        else
        begin
            // every slot counts, including cleared (0,0) ones
            for (int k = 0; k < RING_DEPTH; k++)
                if (hist_sender[k] == snd && hist_number[k] == num)
                    hit = 1'b1;
            if (hit)
                rec.verdict = VERDICT_DUPLICATE;
            else
            begin
                p = hist_ptr;
                if (p >= RING_DEPTH)
                    p = 0;
                hist_sender[p] = snd;
                hist_number[p] = num;
                rec.slot       = p[SLOT_W-1:0];
                p              = p + 1;
                if (p >= RING_DEPTH)
                    p = 0;
                hist_ptr = p[7:0];
            end
        end
        return rec;
    endfunction

    // Queue helpers for the stimulus builder
    task automatic add_packet(input logic pv, input logic [ID_W-1:0] snd,
                              input logic [NUM_W-1:0] num, input int unsigned gap);
        stim_entry_t e;
        e        = '0;
        e.kind   = STIM_PACKET;
        e.pvalid = pv;
        e.sender = snd;
        e.number = num;
        e.gap    = gap[4:0];
        pending_stim.push_back(e);
        recent_pairs.push_back({snd, num});
        if (recent_pairs.size() > 80)
            void'(recent_pairs.pop_front());
    endtask

    task automatic add_control(input stim_kind_t kind, input logic [ID_W-1:0] own);
        stim_entry_t e;
        e      = '0;
        e.kind = kind;
        e.own  = own;
        pending_stim.push_back(e);
    endtask

    // One random packet: mostly pairs from a small pool so that duplicates,
    // forwards and evictions from the ring all show up, plus full-range noise.
    task automatic add_random_packet(input logic [ID_W-1:0] own, input bit calm);
        logic        pv;
        logic [63:0] pair;
        int unsigned sel;
        int unsigned gap;
        pv  = ($urandom_range(0, 9) != 0);
        gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
        sel = $urandom_range(0, 99);
        if (sel < 25 && recent_pairs.size() > 0)
            pair = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
        else
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                pair[63:32] = own;
            else if (sel < 3)
                pair[63:32] = $urandom;
            else
                pair[63:32] = sender_pool[$urandom_range(0, 7)];
            if ($urandom_range(0, 9) < 2)
                pair[31:0] = $urandom;
            else
                pair[31:0] = $urandom_range(0, 11);
        end
        add_packet(pv, pair[63:32], pair[31:0], gap);
    endtask

    // Driver: change inputs at the falling edge, one nonblocking write per signal
    always @(negedge clk)
    begin
        logic vld_next;
        logic cfg_next;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_wr_en <= 1'b0;
        end
        else
        begin
            vld_next = in_valid;
            cfg_next = 1'b0;
            // drop valid once the transfer has happened
            if (drv_state == DRV_HOLD && in_fire)
            begin
                vld_next  = 1'b0;
                drv_state = DRV_FETCH;
            end
            if (drv_state == DRV_FETCH && pending_stim.size() != 0)
            begin
                cur_stim = pending_stim.pop_front();
                if (cur_stim.kind == STIM_PACKET)
                begin
                    tx_gap    = cur_stim.gap;
                    drv_state = DRV_GAP;
                end
                else
                    drv_state = DRV_WAIT_IDLE;
            end
            // hold off until every expected verdict has come back
            if (drv_state == DRV_WAIT_IDLE && verdict_q.size() == 0 && !in_valid)
            begin
                if (cur_stim.kind == STIM_CONFIG)
                begin
                    cfg_next = 1'b1;
                    cfg_wr_data <= cur_stim.own;
                end
                drv_state = DRV_FETCH;
            end
            if (drv_state == DRV_GAP)
            begin
                if (tx_gap == 0)
                begin
                    vld_next = 1'b1;
                    packet_valid   <= cur_stim.pvalid;
                    sender_id      <= cur_stim.sender;
                    message_number <= cur_stim.number;
                    drv_state = DRV_HOLD;
                end
                else
                    tx_gap--;
            end
            in_valid  <= vld_next;
            cfg_wr_en <= cfg_next;
        end
    end

    // Receiver stall: draw a wait after each output transfer, with calm runs
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait = $urandom_range(0, MAX_WAIT);
        end
        else
        begin
            if (out_fire)
            begin
                if (rx_calm != 0)
                begin
                    rx_calm--;
                    rx_wait = 0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    rx_calm = 20;
                    rx_wait = 0;
                end
                else
                    rx_wait = $urandom_range(0, MAX_WAIT);
            end
            if (rx_wait == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                rx_wait--;
            end
        end
    end

    // Monitor: sample at the rising edge, predict on input transfers,
    // check output transfers against the oldest expectation
    always @(posedge clk)
    begin
        verdict_rec_t want;
        if (!rst_n)
        begin
            model_own_id = '0;
            hist_ptr     = '0;
            for (int k = 0; k < RING_DEPTH; k++)
            begin
                hist_sender[k] = '0;
                hist_number[k] = '0;
            end
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
        end
        else
        begin
            in_fire  <= in_valid && in_ready;
            out_fire <= out_valid && out_ready;

            if (cfg_wr_en)
                model_own_id = cfg_wr_data;

            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result verdict=%0d slot=%0d",
                             $time, verdict, slot_written);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (verdict !== want.verdict)
                    begin
                        err_count++;
                        $display("%0t: verdict mismatch expected=%0d actual=%0d",
                                 $time, want.verdict, verdict);
                    end
                    if (slot_written !== want.slot)
                    begin
                        err_count++;
                        $display("%0t: slot_written mismatch expected=%0d actual=%0d",
                                 $time, want.slot, slot_written);
                    end
                end
            end

            if (in_valid && in_ready)
                verdict_q.push_back(judge_packet(packet_valid, sender_id, message_number));

            // watchdog on cycles with no transfer on either channel
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, verdict_q.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Build the stimulus, run reset, wait for the drain, report
    initial
    begin
        logic [ID_W-1:0] own;
        bit              calm;

        sender_pool[0] = 32'h0000_0000;
        sender_pool[1] = 32'h0000_0001;
        sender_pool[2] = 32'h0000_0002;
        sender_pool[3] = 32'h0000_0003;
        sender_pool[4] = 32'hFFFF_FFFF;
        sender_pool[5] = 32'h8000_0000;
        sender_pool[6] = $urandom;
        sender_pool[7] = $urandom;

        // Directed part, own id still at its reset value of zero
        add_packet(1'b1, 32'h0000_0000, 32'h0000_0000, 0);  // (0,0) from own id 0: own
        add_packet(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3);  // invalid, all ones
        add_packet(1'b1, 32'h0000_0005, 32'h0000_0007, 0);  // forward to slot 0
        add_control(STIM_CONFIG, 32'hFFFF_FFFF);
        add_packet(1'b1, 32'h0000_0000, 32'h0000_0000, 0);  // cleared ring: duplicate
        add_packet(1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1);  // own id all ones
        add_packet(1'b1, 32'h0000_0001, 32'hFFFF_FFFF, 0);  // forward
        add_packet(1'b1, 32'h0000_0001, 32'hFFFF_FFFF, 0);  // same pair: duplicate
        add_packet(1'b0, 32'h0000_0001, 32'hFFFF_FFFF, 2);  // invalid beats duplicate
        add_packet(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 0);  // invalid beats own
        add_packet(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 18);
        add_packet(1'b1, 32'hFFFF_FFFE, 32'h0000_0001, 0);
        add_packet(1'b1, 32'h0000_0005, 32'h0000_0007, 0);  // still in ring: duplicate
        add_control(STIM_CONFIG, 32'h0000_0001);
        add_packet(1'b1, 32'h0000_0001, 32'hFFFF_FFFF, 0);  // own beats duplicate
        add_packet(1'b1, 32'h0000_0002, 32'h0000_0000, 5);
        add_packet(1'b1, 32'h0000_0000, 32'h0000_0000, 0);  // cleared ring again
        add_control(STIM_DRAIN, '0);
        add_packet(1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 0);
        add_packet(1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 0);

        // Random phases, each with its own id setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0:       own = 32'h0000_0000;
                1:       own = 32'hFFFF_FFFF;
                2:       own = sender_pool[$urandom_range(0, 7)];
                default: own = $urandom;
            endcase
            calm = (ph == 3 || ph == 7);
            add_control(STIM_CONFIG, own);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                add_random_packet(own, calm || ($urandom_range(0, 7) == 0));
                if ($urandom_range(0, 49) == 0)
                    add_control(STIM_DRAIN, '0);
            end
        end

        // Hold reset, then release it away from the rising edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the last transfer and the last verdict
        while (!(pending_stim.size() == 0 && drv_state == DRV_FETCH && !in_valid
                 && verdict_q.size() == 0))
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (verdict_q.size() != 0)
        begin
            err_count++;
            $display("%0t: %0d expected results never arrived", $time, verdict_q.size());
        end
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
